@@ rtl/core/sensor_fault_band_qualifier_core_assert.svh @@
// assertion macros used by the checker file
`ifndef SENSOR_FAULT_BAND_QUALIFIER_CORE_ASSERT_SVH
`define SENSOR_FAULT_BAND_QUALIFIER_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SFBQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define SFBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/core/sfbq_pkg.sv @@
`timescale 1ns / 1ps
package sfbq_pkg;

	localparam int RD_W       = 10;
	localparam int BANDS      = 4;
	localparam int CFG_NUM    = 8;
	localparam int CFG_IDX_W  = 3;

	localparam int QUAL_COUNT = 50;
	localparam int QUAL_W     = 6;

	localparam int CONTACT_COUNT_MAX = 10;
	localparam int CONTACT_W         = 4;

	localparam logic [RD_W-1:0] CONTACT_LOW  = RD_W'(100);
	localparam logic [RD_W-1:0] CONTACT_HIGH = RD_W'(200);
	localparam logic [RD_W-1:0] STARTUP_HOLD = RD_W'(10);

	typedef enum logic [2:0] {
		ST_UNDET = 3'd0,
		ST_ON    = 3'd1,
		ST_OFF   = 3'd2,
		ST_SHORT = 3'd3,
		ST_OPEN  = 3'd4
	} sens_state_t;

	typedef enum logic [1:0] {
		CT_UNDET = 2'd0,
		CT_ON    = 2'd1,
		CT_OFF   = 2'd2
	} ct_state_t;

	typedef enum logic [1:0] {
		BAND_OPEN  = 2'd0,
		BAND_SHORT = 2'd1,
		BAND_ON    = 2'd2,
		BAND_OFF   = 2'd3
	} band_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEMP_OPEN  = 3'd0,
		CFG_TEMP_SHORT = 3'd1,
		CFG_TEMP_ON    = 3'd2,
		CFG_TEMP_OFF   = 3'd3,
		CFG_HUM_OPEN   = 3'd4,
		CFG_HUM_SHORT  = 3'd5,
		CFG_HUM_ON     = 3'd6,
		CFG_HUM_OFF    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [RD_W-1:0] lim_open;
		logic [RD_W-1:0] lim_short;
		logic [RD_W-1:0] lim_on;
		logic [RD_W-1:0] lim_off;
	} band_limits_t;

	localparam logic [RD_W-1:0] CFG_RESET [CFG_NUM] = '{
		RD_W'(680), RD_W'(15), RD_W'(195), RD_W'(145),
		RD_W'(670), RD_W'(20), RD_W'(510), RD_W'(540)
	};

	function automatic sens_state_t band_code(input band_t b);
		sens_state_t s;
		case (b)
			BAND_OPEN:  s = ST_OPEN;
			BAND_SHORT: s = ST_SHORT;
			BAND_ON:    s = ST_ON;
			BAND_OFF:   s = ST_OFF;
			default:    s = ST_UNDET;
		endcase
		return s;
	endfunction

endpackage

@@ rtl/core/sensor_fault_band_qualifier_core.sv @@
// sensor fault band qualifier: window comparators with persistence counters
// input channel: in_valid / in_ready carry one evaluation tick per request,
//   four 10-bit sensor readings plus the uptime in seconds
// output channel: out_valid / out_ready carry one result request per input,
//   four 3-bit sensor states and eight bits of packed contact states
// configuration: cfg_wr_en writes cfg_data into limit register cfg_index,
//   to be used only while no request is in flight
// a request taken is registered in the input register, qualified from there into
//   the result register, and then offered on out_valid
// throughput: one request per cycle while the receiver does not stall; every band
//   and contact counter is updated directly, so nothing loops or iterates
// a stalled receiver holds the result register; one further request waits in
//   the input register and in_ready drops only when both are full
// reset clears all counters, sets every state to undetermined and loads the
//   default limits; both registers come out of reset empty
`timescale 1ns / 1ps
module sensor_fault_band_qualifier_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// input requests
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sfbq_pkg::RD_W-1:0]      temp_motor_one,
	input  logic [sfbq_pkg::RD_W-1:0]      temp_motor_two,
	input  logic [sfbq_pkg::RD_W-1:0]      hum_motor_one,
	input  logic [sfbq_pkg::RD_W-1:0]      hum_motor_two,
	input  logic [sfbq_pkg::RD_W-1:0]      uptime_seconds,
	// result requests
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     temp_state_one,
	output logic [2:0]                     temp_state_two,
	output logic [2:0]                     hum_state_one,
	output logic [2:0]                     hum_state_two,
	output logic [7:0]                     contact_states,
	// limit register writes
	input  logic                           cfg_wr_en,
	input  logic [sfbq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfbq_pkg::RD_W-1:0]      cfg_data
);
	import sfbq_pkg::*;

	// limit registers
	logic [RD_W-1:0] cfg_q [CFG_NUM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_NUM; i++) begin
				cfg_q[i] <= CFG_RESET[i];
			end
		end else if (cfg_wr_en) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	band_limits_t temp_lim;
	band_limits_t hum_lim;

	assign temp_lim = '{lim_open:  cfg_q[CFG_TEMP_OPEN],
	                    lim_short: cfg_q[CFG_TEMP_SHORT],
	                    lim_on:    cfg_q[CFG_TEMP_ON],
	                    lim_off:   cfg_q[CFG_TEMP_OFF]};
	assign hum_lim  = '{lim_open:  cfg_q[CFG_HUM_OPEN],
	                    lim_short: cfg_q[CFG_HUM_SHORT],
	                    lim_on:    cfg_q[CFG_HUM_ON],
	                    lim_off:   cfg_q[CFG_HUM_OFF]};

	// input register
	logic            vld_s1;
	logic [RD_W-1:0] t1_s1, t2_s1, h1_s1, h2_s1, up_s1;
	logic            adv;

	// the input stage moves on whenever the result register is free or emptying
	assign adv      = vld_s1 && (!out_valid || out_ready);
	assign in_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			t1_s1 <= temp_motor_one;
			t2_s1 <= temp_motor_two;
			h1_s1 <= hum_motor_one;
			h2_s1 <= hum_motor_two;
			up_s1 <= uptime_seconds;
		end
	end

	// qualification, one unit per sensor
	logic        running;
	sens_state_t sens_nxt [4];
	ct_state_t   ct_nxt   [4];

	// start-up hold forces every sensor off
	assign running = up_s1 > STARTUP_HOLD;

	sfbq_band_qual u_temp_one (
		.clk(clk), .arst_n(arst_n), .upd(adv), .running(running), .is_hum(1'b0),
		.reading(t1_s1), .lim(temp_lim), .state_nxt(sens_nxt[0])
	);
	sfbq_band_qual u_temp_two (
		.clk(clk), .arst_n(arst_n), .upd(adv), .running(running), .is_hum(1'b0),
		.reading(t2_s1), .lim(temp_lim), .state_nxt(sens_nxt[1])
	);
	sfbq_band_qual u_hum_one (
		.clk(clk), .arst_n(arst_n), .upd(adv), .running(running), .is_hum(1'b1),
		.reading(h1_s1), .lim(hum_lim), .state_nxt(sens_nxt[2])
	);
	sfbq_band_qual u_hum_two (
		.clk(clk), .arst_n(arst_n), .upd(adv), .running(running), .is_hum(1'b1),
		.reading(h2_s1), .lim(hum_lim), .state_nxt(sens_nxt[3])
	);

	// contact detectors ignore uptime; channel order t1, h1, t2, h2
	sfbq_contact u_ct0 (
		.clk(clk), .arst_n(arst_n), .upd(adv), .reading(t1_s1), .state_nxt(ct_nxt[0])
	);
	sfbq_contact u_ct1 (
		.clk(clk), .arst_n(arst_n), .upd(adv), .reading(h1_s1), .state_nxt(ct_nxt[1])
	);
	sfbq_contact u_ct2 (
		.clk(clk), .arst_n(arst_n), .upd(adv), .reading(t2_s1), .state_nxt(ct_nxt[2])
	);
	sfbq_contact u_ct3 (
		.clk(clk), .arst_n(arst_n), .upd(adv), .reading(h2_s1), .state_nxt(ct_nxt[3])
	);

	// result register
	logic       vld_s2;
	logic [2:0] ts1_s2, ts2_s2, hs1_s2, hs2_s2;
	logic [7:0] ct_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || out_ready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ts1_s2 <= sens_nxt[0];
			ts2_s2 <= sens_nxt[1];
			hs1_s2 <= sens_nxt[2];
			hs2_s2 <= sens_nxt[3];
			ct_s2  <= {ct_nxt[3], ct_nxt[2], ct_nxt[1], ct_nxt[0]};
		end
	end

	assign out_valid      = vld_s2;
	assign temp_state_one = ts1_s2;
	assign temp_state_two = ts2_s2;
	assign hum_state_one  = hs1_s2;
	assign hum_state_two  = hs2_s2;
	assign contact_states = ct_s2;

endmodule

@@ rtl/core/sfbq_band_qual.sv @@
`timescale 1ns / 1ps
module sfbq_band_qual (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       upd,
	input  logic                       running,
	input  logic                       is_hum,
	input  logic [sfbq_pkg::RD_W-1:0]  reading,
	input  sfbq_pkg::band_limits_t     lim,
	output sfbq_pkg::sens_state_t      state_nxt
);
	import sfbq_pkg::*;

	localparam logic [QUAL_W-1:0] QUAL_MAX = QUAL_W'(QUAL_COUNT);

	logic [QUAL_W-1:0] cnt_q   [BANDS];
	logic [QUAL_W-1:0] cnt_nxt [BANDS];
	sens_state_t       state_q;
	band_t             band;
	logic              dead;

	// first matching band wins
	always_comb begin
		dead = 1'b0;
		band = BAND_OPEN;
		if (reading > lim.lim_open) begin
			band = BAND_OPEN;
		end else if (reading < lim.lim_short) begin
			band = BAND_SHORT;
		end else if (is_hum ? (reading < lim.lim_on) : (reading > lim.lim_on)) begin
			band = BAND_ON;
		end else if (is_hum ? (reading > lim.lim_off) : (reading < lim.lim_off)) begin
			band = BAND_OFF;
		end else begin
			dead = 1'b1;
		end
	end

	always_comb begin
		for (int k = 0; k < BANDS; k++) begin
			if (2'(k) == band) begin
				cnt_nxt[k] = (cnt_q[k] < QUAL_MAX) ? cnt_q[k] + 1'b1 : cnt_q[k];
			end else begin
				cnt_nxt[k] = '0;
			end
		end
	end

	always_comb begin
		if (!running) begin
			state_nxt = ST_OFF;
		end else if (dead) begin
			state_nxt = state_q;
		end else if (cnt_nxt[band] >= QUAL_MAX) begin
			state_nxt = band_code(band);
		end else begin
			state_nxt = state_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < BANDS; k++) begin
				cnt_q[k] <= '0;
			end
			state_q <= ST_UNDET;
		end else if (upd) begin
			state_q <= state_nxt;
			// start-up hold and dead zone keep the counters
			if (running && !dead) begin
				cnt_q <= cnt_nxt;
			end
		end
	end

endmodule

@@ rtl/core/sfbq_contact.sv @@
`timescale 1ns / 1ps
module sfbq_contact (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      upd,
	input  logic [sfbq_pkg::RD_W-1:0] reading,
	output sfbq_pkg::ct_state_t       state_nxt
);
	import sfbq_pkg::*;

	localparam logic [CONTACT_W-1:0] CNT_MAX = CONTACT_W'(CONTACT_COUNT_MAX);
	localparam logic [CONTACT_W-1:0] CNT_ON  = CONTACT_W'(CONTACT_COUNT_MAX - 1);
	localparam logic [CONTACT_W-1:0] CNT_OFF = CONTACT_W'(1);

	logic [CONTACT_W-1:0] cnt_q;
	logic [CONTACT_W-1:0] cnt_nxt;
	ct_state_t            state_q;

	always_comb begin
		cnt_nxt = cnt_q;
		if (reading < CONTACT_LOW) begin
			if (cnt_q < CNT_MAX) begin
				cnt_nxt = cnt_q + 1'b1;
			end
		end else if (reading > CONTACT_HIGH) begin
			if (cnt_q != '0) begin
				cnt_nxt = cnt_q - 1'b1;
			end
		end
		if (cnt_nxt > CNT_MAX) begin
			cnt_nxt = CNT_MAX;
		end
	end

	always_comb begin
		if (cnt_nxt >= CNT_ON) begin
			state_nxt = CT_ON;
		end else if (cnt_nxt <= CNT_OFF) begin
			state_nxt = CT_OFF;
		end else begin
			state_nxt = state_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			state_q <= CT_UNDET;
		end else if (upd) begin
			cnt_q   <= cnt_nxt;
			state_q <= state_nxt;
		end
	end

endmodule

@@ rtl/core/sfbq_checker.sv @@
`timescale 1ns / 1ps
`include "sensor_fault_band_qualifier_core_assert.svh"
module sfbq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] temp_state_one,
	input logic [2:0] temp_state_two,
	input logic [2:0] hum_state_one,
	input logic [2:0] hum_state_two,
	input logic [7:0] contact_states
);
	import sfbq_pkg::*;

	logic codes_ok;

	// no state code above open, no contact code three
	assign codes_ok = (temp_state_one <= ST_OPEN) && (temp_state_two <= ST_OPEN) &&
	                  (hum_state_one <= ST_OPEN) && (hum_state_two <= ST_OPEN) &&
	                  (contact_states[1:0] != 2'd3) && (contact_states[3:2] != 2'd3) &&
	                  (contact_states[5:4] != 2'd3) && (contact_states[7:6] != 2'd3);

	`SFBQ_ASSERT_NOW(a_codes_legal, clk, arst_n, out_valid, codes_ok)
	// an empty result register always leaves room for a request
	`SFBQ_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)
	`SFBQ_ASSERT_NEXT(a_out_held, clk, arst_n, out_valid && !out_ready, out_valid)
	`SFBQ_ASSERT_NEXT(a_ct_held, clk, arst_n, out_valid && !out_ready, $stable(contact_states))

endmodule

bind sensor_fault_band_qualifier_core sfbq_checker u_sfbq_checker (.*);
